// ===== src/qdrt_pkg.sv =====
// Shared types and constants for the query dedupe and route table.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qdrt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam logic [15:0] EXPIRY_RESET = 16'd20;

    // Configuration register indexes (paddr[2] selects the word).
    localparam logic REG_OWN_NODE = 1'b0;
    localparam logic REG_EXPIRY   = 1'b1;

    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_ROUTE = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    // Token that travels down the row of cells, one cell per cycle.
    typedef struct packed {
        logic        valid;
        opcode_t     op;
        logic        hops_nz;
        logic [15:0] origin;
        logic [31:0] seq;
        logic [15:0] peer;
        logic [31:0] now;
        logic        match;
        logic        free;
        logic [15:0] upstream;
    } tok_t;

    // Write of a new entry, broadcast to every cell at the end of a pass.
    typedef struct packed {
        logic        write;
        logic [15:0] origin;
        logic [31:0] seq;
        logic [15:0] upstream;
        logic [31:0] stamp;
    } commit_t;

endpackage

`default_nettype wire

// ===== src/query_dedupe_route_table_core.sv =====
// Top level of the query dedupe and route table: control, registers, cell row.
// Depends on qdrt_pkg and qdrt_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A command word (opcode, from_peer, origin_node, sequence_number, hops_left)
// is taken at a rising edge where start is high and busy is low. The word
// then walks down a row of TABLE_DEPTH cells, one cell per cycle; each cell
// holds one table entry and folds its own compare, free-slot and expiry
// result into the word before passing it on. Because the first free entry
// and the lowest-numbered match are known only once the whole row has been
// visited, the new entry of a check is written by a broadcast at the end of
// the pass into the one cell that claimed it.
// The result word appears on the result ports for one cycle with done high
// once the word has left the last cell. busy stays high from the accept edge
// until the edge that raises done, so the next word is taken at the edge after
// that one at the earliest: no new word before the last one's result is out.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_n low, asynchronous) clears all entry valid bits, the seconds
// counter, busy and done, and loads own_node_id = 0 and expiry_seconds = 20.
// The APB port holds own_node_id at byte 0 and expiry_seconds at byte 4;
// write it only while the block is idle.
module query_dedupe_route_table_core
    import qdrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] from_peer,
    input  wire logic [15:0] origin_node,
    input  wire logic [31:0] sequence_number,
    input  wire logic [7:0]  hops_left,
    output logic             done,
    output logic             forward,
    output logic             duplicate,
    output logic             table_full,
    output logic             route_hit,
    output logic [15:0]      upstream_peer,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic [31:0] seconds_reg;
    logic [31:0] seconds_next;
    logic [15:0] own_node_reg;
    logic [15:0] expiry_reg;
    logic        forward_reg;
    logic        duplicate_reg;
    logic        table_full_reg;
    logic        route_hit_reg;
    logic [15:0] upstream_reg;

    logic        accept;
    logic        cfg_write;
    tok_t        launch;
    tok_t        tok_chain [TABLE_DEPTH+1];
    tok_t        tail;
    commit_t     commit;
    logic        chk;
    logic        res_forward;
    logic        res_duplicate;
    logic        res_full;
    logic        res_hit;

    assign accept    = start && !busy_reg;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_reg <= '0;
            expiry_reg   <= EXPIRY_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_OWN_NODE)
            begin
                own_node_reg <= pwdata[15:0];
            end
            else
            begin
                expiry_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_EXPIRY) ? {16'd0, expiry_reg} : {16'd0, own_node_reg};

    // A tick bumps the clock before the pass, so the cells compare against
    // the new second. A check stamps its entry with the current second.
    assign seconds_next = (accept && (opcode_t'(opcode) == OP_TICK)) ? seconds_reg + 32'd1
                                                                     : seconds_reg;

    // The word entering the row. A query from this node starts out as a match;
    // a check with nonzero hops_left then ends as a duplicate, table untouched.
    always_comb
    begin
        launch          = '0;
        launch.valid    = accept;
        launch.op       = opcode_t'(opcode);
        launch.hops_nz  = (hops_left != 8'd0);
        launch.origin   = origin_node;
        launch.seq      = sequence_number;
        launch.peer     = from_peer;
        launch.now      = seconds_next;
        launch.match    = (opcode_t'(opcode) == OP_CHECK) && (origin_node == own_node_reg);
        launch.free     = 1'b0;
        launch.upstream = '0;
    end

    assign tok_chain[0] = launch;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        qdrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .expiry  (expiry_reg),
            .tok_in  (tok_chain[i]),
            .commit  (commit),
            .tok_out (tok_chain[i+1])
        );
    end

    assign tail = tok_chain[TABLE_DEPTH];

    // Decision once the word has seen every entry.
    assign chk           = (tail.op == OP_CHECK) && tail.hops_nz;
    assign res_duplicate = chk && tail.match;
    assign res_forward   = chk && !tail.match && tail.free;
    assign res_full      = chk && !tail.match && !tail.free;
    assign res_hit       = (tail.op == OP_ROUTE) && tail.match;

    always_comb
    begin
        commit.write    = tail.valid && res_forward;
        commit.origin   = tail.origin;
        commit.seq      = tail.seq;
        commit.upstream = tail.peer;
        commit.stamp    = tail.now;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            seconds_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            done_reg    <= tail.valid;
            seconds_reg <= seconds_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            forward_reg    <= res_forward;
            duplicate_reg  <= res_duplicate;
            table_full_reg <= res_full;
            route_hit_reg  <= res_hit;
            upstream_reg   <= res_hit ? tail.upstream : 16'd0;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign forward       = forward_reg;
    assign duplicate     = duplicate_reg;
    assign table_full    = table_full_reg;
    assign route_hit     = route_hit_reg;
    assign upstream_peer = upstream_reg;

    // A word leaves the row only while a command is in flight.
    a_tail_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> busy_reg)
        else $error("word left the cell row with no command in flight");

    // A result is never shown while the block still counts as busy.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while busy");

    // An accepted command keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy did not rise after accept");

    // At most one outcome flag per result word.
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $onehot0({forward_reg, duplicate_reg, table_full_reg, route_hit_reg}))
        else $error("more than one outcome flag set");

    // The clock only moves on an accepted tick.
    a_seconds_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(seconds_reg))
        else $error("seconds counter moved without a tick");

endmodule

`default_nettype wire

// ===== src/qdrt_cell.sv =====
// One table entry of the query dedupe and route table, with its token stage.
// Depends on qdrt_pkg for the token and commit types.
`timescale 1ns / 1ps
`default_nettype none

module qdrt_cell
    import qdrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] expiry,
    input  wire tok_t        tok_in,
    input  wire commit_t     commit,
    output tok_t             tok_out
);

    logic        valid_reg;
    logic        valid_next;
    logic        claim_reg;
    logic        claim_next;
    logic [15:0] origin_reg;
    logic [31:0] seq_reg;
    logic [15:0] upstream_reg;
    logic [31:0] stamp_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        hit_here;
    logic [31:0] age;
    logic        expire;

    assign hit_here = valid_reg && (origin_reg == tok_in.origin) && (seq_reg == tok_in.seq);
    assign age      = tok_in.now - stamp_reg;
    assign expire   = valid_reg && (tok_in.op == OP_TICK) && (age > {16'd0, expiry});

    always_comb
    begin
        tok_next = tok_in;
        tok_next.match = tok_in.match | hit_here;
        tok_next.free  = tok_in.free | !valid_reg;
        if (!tok_in.match && hit_here)
        begin
            tok_next.upstream = upstream_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (commit.write && claim_reg)
        begin
            valid_next = 1'b1;
        end
        else if (tok_in.valid && expire)
        begin
            valid_next = 1'b0;
        end
    end

    // The first empty entry seen by a pass claims the slot for a later write.
    assign claim_next = tok_in.valid ? (!valid_reg && !tok_in.free) : claim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            claim_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            claim_reg <= claim_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit.write && claim_reg)
        begin
            origin_reg   <= commit.origin;
            seq_reg      <= commit.seq;
            upstream_reg <= commit.upstream;
            stamp_reg    <= commit.stamp;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== sim/query_dedupe_route_table_core_tb.sv =====
// Self-checking testbench for query_dedupe_route_table_core: it drives command words and
// APB register writes, and predicts every result word from its own model of the table.
// Depends on qdrt_pkg and on the RTL of the block; it needs no other file.
`timescale 1ns / 1ps

module query_dedupe_route_table_core_tb;

    import qdrt_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    // A healthy run never goes this many cycles without an accepted command word,
    // a result word or a register access.
    localparam int STALL_LIMIT = 2000;
    localparam int POOL_SIZE = 8;

    // One result word of the block, as the predictor works it out.
    typedef struct packed {
        logic        fwd;
        logic        dup;
        logic        full;
        logic        hit;
        logic [15:0] upstream;
    } verdict_t;

    // The scoreboard keeps its own copy of the table, the seconds counter and both
    // registers, and a queue of the result words that accepted commands still owe.
    class dedupe_table_tracker;
        bit          entry_used [TABLE_DEPTH];
        bit [15:0]   entry_origin [TABLE_DEPTH];
        bit [31:0]   entry_seq [TABLE_DEPTH];
        bit [15:0]   entry_upstream [TABLE_DEPTH];
        bit [31:0]   entry_stamp [TABLE_DEPTH];
        bit [31:0]   seconds;
        bit [15:0]   own_id;
        bit [15:0]   expiry;
        verdict_t    owed_verdicts [$];
        int          fail_count;
        int          commands;
        int          words_checked;
        int          forwarded;
        int          duplicates;
        int          refused_full;
        int          route_hits;
        int          ticks;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                entry_used[i] = 1'b0;
            end
            seconds = '0;
            own_id = '0;
            expiry = EXPIRY_RESET;
        endfunction

        task report_mismatch(input string what);
            $display("%0t ns: mismatch: %s", $time, what);
            fail_count++;
        endtask

        function void set_register(input logic reg_sel, input logic [15:0] value);
            if (reg_sel == REG_OWN_NODE)
                own_id = value;
            else
                expiry = value;
        endfunction

        // Lowest-numbered live entry that holds this source and sequence, or -1.
        function int find_entry(input logic [15:0] origin, input logic [31:0] seq);
            int found;
            found = -1;
            for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            begin
                if (entry_used[i] && entry_origin[i] == origin && entry_seq[i] == seq)
                    found = i;
            end
            return found;
        endfunction

        // Applies one accepted command word to the table and queues the word it owes.
        function void log_command(input opcode_t op, input logic [15:0] peer,
                                  input logic [15:0] origin, input logic [31:0] seq,
                                  input logic [7:0] hops);
            verdict_t   v;
            int         slot;
            bit [31:0]  age;
            v = '0;
            slot = -1;
            commands++;
            case (op)
                OP_CHECK:
                begin
                    if (hops != 8'd0)
                    begin
                        if (origin == own_id || find_entry(origin, seq) >= 0)
                        begin
                            v.dup = 1'b1;
                        end
                        else
                        begin
                            for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                            begin
                                if (!entry_used[i])
                                    slot = i;
                            end
                            if (slot < 0)
                            begin
                                v.full = 1'b1;
                            end
                            else
                            begin
                                entry_used[slot] = 1'b1;
                                entry_origin[slot] = origin;
                                entry_seq[slot] = seq;
                                entry_upstream[slot] = peer;
                                entry_stamp[slot] = seconds;
                                v.fwd = 1'b1;
                            end
                        end
                    end
                end
                OP_ROUTE:
                begin
                    slot = find_entry(origin, seq);
                    if (slot >= 0)
                    begin
                        v.hit = 1'b1;
                        v.upstream = entry_upstream[slot];
                    end
                end
                OP_TICK:
                begin
                    seconds = seconds + 32'd1;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        age = seconds - entry_stamp[i];
                        if (entry_used[i] && age > {16'd0, expiry})
                            entry_used[i] = 1'b0;
                    end
                    ticks++;
                end
                default:
                begin
                end
            endcase
            forwarded += v.fwd;
            duplicates += v.dup;
            refused_full += v.full;
            route_hits += v.hit;
            owed_verdicts.insert(owed_verdicts.size(), v);
        endfunction

        task check_verdict(input verdict_t got);
            verdict_t want;
            if (owed_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("result word %h with no command outstanding", got));
            end
            else
            begin
                want = owed_verdicts.pop_front();
                words_checked++;
                if (got.fwd !== want.fwd)
                    report_mismatch($sformatf("forward %b, predicted %b", got.fwd, want.fwd));
                if (got.dup !== want.dup)
                    report_mismatch($sformatf("duplicate %b, predicted %b", got.dup, want.dup));
                if (got.full !== want.full)
                    report_mismatch($sformatf("table_full %b, predicted %b",
                                              got.full, want.full));
                if (got.hit !== want.hit)
                    report_mismatch($sformatf("route_hit %b, predicted %b", got.hit, want.hit));
                if (got.upstream !== want.upstream)
                    report_mismatch($sformatf("upstream_peer %h, predicted %h",
                                              got.upstream, want.upstream));
            end
        endtask

        function int outstanding();
            return owed_verdicts.size();
        endfunction
    endclass

    // Clock, reset and every input of the block start at a known value.
    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    opcode_t     opcode = OP_CHECK;
    logic [15:0] from_peer = '0;
    logic [15:0] origin_node = '0;
    logic [31:0] sequence_number = '0;
    logic [7:0]  hops_left = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic        busy;
    logic        done;
    logic        forward;
    logic        duplicate;
    logic        table_full;
    logic        route_hit;
    logic [15:0] upstream_peer;
    logic [31:0] prdata;
    logic        pready;

    dedupe_table_tracker tracker = new();
    logic [15:0] origin_pool [POOL_SIZE];
    int          quiet_cycles = 0;

    query_dedupe_route_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .from_peer(from_peer),
        .origin_node(origin_node),
        .sequence_number(sequence_number),
        .hops_left(hops_left),
        .done(done),
        .forward(forward),
        .duplicate(duplicate),
        .table_full(table_full),
        .route_hit(route_hit),
        .upstream_peer(upstream_peer),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Monitor. All stimulus changes through nonblocking assignments, so at a rising
    // edge this block sees the values that the block itself samples. A result word is
    // checked before a command word accepted at the same edge is predicted, which keeps
    // the owed queue in order. The watchdog also lives here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_verdict('{forward, duplicate, table_full, route_hit,
                                        upstream_peer});
            if (start && !busy)
                tracker.log_command(opcode, from_peer, origin_node, sequence_number,
                                    hops_left);
        end
        if (done || (start && !busy) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no progress in %0d cycles, %0d result words owed.",
                     STALL_LIMIT, tracker.outstanding());
            $display("FAILURE");
            $finish;
        end
    end

    // Presents one command word and returns at the edge that accepts it. start is left
    // high, so the caller either follows with the next word or lowers start itself.
    task automatic issue_command(input opcode_t op, input logic [15:0] peer,
                                 input logic [15:0] origin, input logic [31:0] seq,
                                 input logic [7:0] hops);
        start <= 1'b1;
        opcode <= op;
        from_peer <= peer;
        origin_node <= origin;
        sequence_number <= seq;
        hops_left <= hops;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Holds off until every owed result word has come back; start must already be low.
    task automatic wait_for_drain();
        while (tracker.outstanding() > 0)
            @(posedge clk);
        repeat (2)
            @(posedge clk);
    endtask

    // APB write of one register, then a read of it back. The upper half of pwdata
    // carries junk, which the block must drop.
    task automatic write_register(input logic reg_sel, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_register(reg_sel, value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[15:0] !== value)
            tracker.report_mismatch($sformatf("register %0d reads %h, written %h",
                                              reg_sel, prdata[15:0], value));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // One phase of random traffic under one register setting. The origins come from
    // a small pool with this node's own id and the sequences from a narrow window, so
    // duplicates and route hits are common; wide_pct percent are wide random values
    // that log new entries and fill the table. idle_pct is the chance of a gap after a
    // word; gaps are mostly short, sometimes long enough to land anywhere in a pass.
    task automatic run_phase(input logic [15:0] own, input logic [15:0] expiry_value,
                             input int words, input int pct_check, input int pct_route,
                             input int idle_pct, input int wide_pct);
        opcode_t     op;
        logic [15:0] origin;
        logic [31:0] seq;
        logic [31:0] seq_base;
        logic [7:0]  hops;
        int          roll;
        int          gap;
        // The sender pauses here until every owed word is in, so the registers
        // change only while the block is idle.
        wait_for_drain();
        write_register(REG_OWN_NODE, own);
        write_register(REG_EXPIRY, expiry_value);
        origin_pool[0] = own;
        for (int i = 1; i < POOL_SIZE; i++)
            origin_pool[i] = 16'($urandom);
        seq_base = $urandom;
        for (int n = 0; n < words; n++)
        begin
            roll = $urandom_range(99);
            if (roll < pct_check)
                op = OP_CHECK;
            else if (roll < pct_check + pct_route)
                op = OP_ROUTE;
            else
                op = OP_TICK;
            if ($urandom_range(99) < wide_pct)
            begin
                origin = 16'($urandom);
                seq = $urandom;
            end
            else
            begin
                origin = origin_pool[$urandom_range(POOL_SIZE - 1)];
                seq = seq_base + 32'($urandom_range(5));
            end
            hops = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            issue_command(op, 16'($urandom), origin, seq, hops);
            gap = 0;
            if ($urandom_range(99) < idle_pct)
                gap = ($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(1, 40);
            if (gap > 0 || n == words - 1)
                start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset registers (own node 0, expiry 20): a zero
        // hop count that logs nothing, a query from this node, all-ones and all-zero
        // fields, a repeat that must be a duplicate, route hits and misses, a route
        // lookup of a query that was never logged, and ticks.
        issue_command(OP_CHECK, 16'h1111, 16'h1234, 32'd1, 8'd0);
        issue_command(OP_CHECK, 16'h2222, 16'h0000, 32'd9, 8'd5);
        issue_command(OP_CHECK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        issue_command(OP_CHECK, 16'h0001, 16'hFFFF, 32'hFFFF_FFFF, 8'h01);
        issue_command(OP_ROUTE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 8'h00);
        issue_command(OP_ROUTE, 16'h0000, 16'hFFFF, 32'h0000_0000, 8'h00);
        issue_command(OP_CHECK, 16'h0000, 16'h0001, 32'h0000_0000, 8'h01);
        issue_command(OP_CHECK, 16'h5555, 16'h0001, 32'h0000_0001, 8'h80);
        issue_command(OP_ROUTE, 16'hFFFF, 16'h0001, 32'h0000_0000, 8'hFF);
        issue_command(OP_CHECK, 16'h00AA, 16'h00AA, 32'h0000_0007, 8'h00);
        issue_command(OP_ROUTE, 16'h0000, 16'h00AA, 32'h0000_0007, 8'h00);
        issue_command(OP_TICK, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        issue_command(OP_ROUTE, 16'h0000, 16'h0001, 32'h0000_0001, 8'h00);
        issue_command(OP_CHECK, 16'hAAAA, 16'hAAAA, 32'hAAAA_AAAA, 8'hAA);
        issue_command(OP_CHECK, 16'h5555, 16'h5555, 32'h5555_5555, 8'h55);
        issue_command(OP_ROUTE, 16'h0000, 16'hAAAA, 32'hAAAA_AAAA, 8'h00);
        issue_command(OP_ROUTE, 16'h0000, 16'h5555, 32'h5555_5555, 8'h00);
        issue_command(OP_CHECK, 16'h1234, 16'h5555, 32'h5555_5555, 8'h03);
        issue_command(OP_TICK, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00);
        start <= 1'b0;

        // Random phases. The second one never expires anything, so the table fills
        // and new queries are refused; the third one's expiry of one second then
        // clears it within two ticks.
        run_phase(16'($urandom), 16'd20, 320, 55, 30, 0, 25);
        run_phase(16'hFFFF, 16'hFFFF, 260, 80, 20, 47, 60);
        run_phase(16'h0000, 16'd1, 360, 45, 25, 15, 20);
        run_phase(16'($urandom), 16'd3, 400, 50, 30, 47, 20);
        run_phase(16'($urandom), 16'($urandom_range(4, 40)), 440, 55, 30, 15, 20);

        // Everything owed must be in; then a full pass more catches any stray word.
        wait_for_drain();
        repeat (TABLE_DEPTH + 4)
            @(posedge clk);
        if (tracker.outstanding() != 0)
            tracker.report_mismatch($sformatf("%0d result words never arrived",
                                              tracker.outstanding()));

        $display("Ran %0d command words: %0d forwarded, %0d duplicates, %0d refused on a",
                 tracker.commands, tracker.forwarded, tracker.duplicates,
                 tracker.refused_full);
        $display("full table, %0d route hits, %0d ticks; expiry from 1 to 65535, %0d errors.",
                 tracker.route_hits, tracker.ticks, tracker.fail_count);
        if (tracker.fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
